// ----- rtl/wsg_pkg.sv -----
// Shared types and codes for the waveform sample generator.
// Holds register index codes and waveform mode codes; no dependencies.
package wsg_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_WAVE_MODE    = 2'd0,
        CFG_PHASE_STEP   = 2'd1,
        CFG_PEAK_LEVEL   = 2'd2,
        CFG_PHASE_OFFSET = 2'd3
    } t_cfg_reg;

    // Waveform selection
    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SQUARE   = 2'd1,
        WAVE_TRIANGLE = 2'd2,
        WAVE_ZERO     = 2'd3
    } t_wave_mode;

    localparam int unsigned CFG_ADDR_W  = 2;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned INDEX_W     = 32;
    localparam int unsigned STEP_W      = 32;
    localparam int unsigned OFFSET_W    = 32;
    localparam int unsigned LEVEL_W     = 15;

    // pi/2 in Q30, truncated
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

endpackage

// ----- rtl/wsg_sine_rom.sv -----
// Quarter-wave sine ROM with registered read, 2^TABLE_ADDR_BITS + 1 entries.
// Contents are built at elaboration from a Q30 Taylor series; uses wsg_pkg.
module wsg_sine_rom #(
    parameter int unsigned TABLE_ADDR_BITS = 10,
    parameter int unsigned SAMPLE_BITS     = 16
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [TABLE_ADDR_BITS:0]   i_addr,
    output logic [SAMPLE_BITS-2:0]     o_data
);
    import wsg_pkg::*;

    localparam int unsigned TAB_N = 1 << TABLE_ADDR_BITS;
    localparam logic [63:0] FULL_SCALE = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

    typedef logic [SAMPLE_BITS-2:0] t_rom [0:TAB_N];

    // Odd Taylor series through the x^11 term, every term truncated
    function automatic logic [63:0] f_sine_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] prod;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int n = 1; n <= 5; n++) begin
            prod = (term * x2) >> 30;
            unique case (n)
                1:       term = prod / 64'd6;
                2:       term = prod / 64'd20;
                3:       term = prod / 64'd42;
                4:       term = prod / 64'd72;
                default: term = prod / 64'd110;
            endcase
            if ((n % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    // Scale each entry to full scale with rounding and clamp
    function automatic t_rom f_build();
        t_rom        rom;
        logic [63:0] x;
        logic [63:0] v;
        for (int k = 0; k <= TAB_N; k++) begin
            x = (HALF_PI_Q30 * 64'(k)) >> TABLE_ADDR_BITS;
            v = (f_sine_q30(x) * FULL_SCALE + (64'd1 << 29)) >> 30;
            if (v > FULL_SCALE) begin
                v = FULL_SCALE;
            end
            rom[k] = v[SAMPLE_BITS-2:0];
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = f_build();

    logic [SAMPLE_BITS-2:0] r_data;

    // Registered read, held while the stage stalls
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= SINE_ROM[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

// ----- rtl/waveform_sample_generator.sv -----
// Top level of the waveform sample generator: five-stage sample pipeline
// and configuration registers. Uses wsg_pkg and wsg_sine_rom.
//
//  Channel   Direction  Payload (low bit up)        Handshake
//  s_axis    in         tdata: sample_index[31:0]    tvalid / tready
//  m_axis    out        tdata: sample_value, 0 pad  tvalid / tready
//  cfg       in         wdata per register index    wr_en, no wait
//
// One sample per clock unless the output stalls; each request passes in order:
// phase multiply, offset and table address, table read with triangle
// multiply, amplitude multiply, rounding and select into the output register.
// Reset (synchronous, active low) clears the stage valid bits and config registers.
// A stall holds only full stages; empty stages keep filling and tready
// falls once every stage holds a sample.
module waveform_sample_generator #(
    parameter int unsigned PHASE_BITS      = 32,
    parameter int unsigned TABLE_ADDR_BITS = 10,
    parameter int unsigned SAMPLE_BITS     = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // sample_index[31:0]
    input  logic [wsg_pkg::INDEX_W-1:0]               i_s_axis_tdata,
    input  logic                                      i_s_axis_tvalid,
    output logic                                      o_s_axis_tready,
    // sample_value[SAMPLE_BITS-1:0], zero filled to whole bytes
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]          o_m_axis_tdata,
    output logic                                      o_m_axis_tvalid,
    input  logic                                      i_m_axis_tready,
    input  logic                                      i_cfg_wr_en,
    input  logic [wsg_pkg::CFG_ADDR_W-1:0]            i_cfg_addr,
    input  logic [wsg_pkg::CFG_DATA_W-1:0]            i_cfg_wdata
);
    import wsg_pkg::*;

    localparam int unsigned TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int unsigned TAB_N   = 1 << TABLE_ADDR_BITS;
    localparam int unsigned TRI_W   = PHASE_BITS + 15;
    localparam int unsigned SIN_W   = SAMPLE_BITS + 14;
    localparam int unsigned VAL_W   = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
    localparam logic [TRI_W-1:0] TRI_HALF = TRI_W'(1) << (PHASE_BITS - 2);
    localparam logic [SIN_W-1:0] SIN_HALF = SIN_W'(1) << (SAMPLE_BITS - 2);
    localparam logic [TABLE_ADDR_BITS:0] TAB_END = (TABLE_ADDR_BITS + 1)'(TAB_N);

    // Configuration registers
    t_wave_mode             r_wave_mode;
    logic [STEP_W-1:0]      r_phase_step;
    logic [LEVEL_W-1:0]     r_peak_level;
    logic [OFFSET_W-1:0]    r_phase_offset;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_mode    <= WAVE_SINE;
            r_phase_step   <= '0;
            r_peak_level   <= '0;
            r_phase_offset <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                CFG_WAVE_MODE:    r_wave_mode    <= t_wave_mode'(i_cfg_wdata[1:0]);
                CFG_PHASE_STEP:   r_phase_step   <= i_cfg_wdata[STEP_W-1:0];
                CFG_PEAK_LEVEL:   r_peak_level   <= i_cfg_wdata[LEVEL_W-1:0];
                CFG_PHASE_OFFSET: r_phase_offset <= i_cfg_wdata[OFFSET_W-1:0];
                default:          r_wave_mode    <= r_wave_mode;
            endcase
        end
    end

    // Stage valid bits and stage enables
    logic r1_valid, r2_valid, r3_valid, r4_valid, r5_valid;
    logic w_en1, w_en2, w_en3, w_en4, w_en5;

    assign w_en5 = !r5_valid || i_m_axis_tready;
    assign w_en4 = !r4_valid || w_en5;
    assign w_en3 = !r3_valid || w_en4;
    assign w_en2 = !r2_valid || w_en3;
    assign w_en1 = !r1_valid || w_en2;

    assign o_s_axis_tready = w_en1;
    assign o_m_axis_tvalid = r5_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else begin
            if (w_en1) r1_valid <= i_s_axis_tvalid;
            if (w_en2) r2_valid <= r1_valid;
            if (w_en3) r3_valid <= r2_valid;
            if (w_en4) r4_valid <= r3_valid;
            if (w_en5) r5_valid <= r4_valid;
        end
    end

    // Stage 1: phase = index * step, modulo one turn
    logic [63:0]            w_phase_prod;
    logic [PHASE_BITS-1:0]  r1_phase;

    assign w_phase_prod = {32'd0, i_s_axis_tdata} * {32'd0, r_phase_step};

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_phase <= w_phase_prod[PHASE_BITS-1:0];
        end
    end

    // Stage 2: add sine offset, fold quadrant into table address, fold triangle
    logic [PHASE_BITS-1:0]      w_sine_phase;
    logic [1:0]                 w_quad;
    logic [TABLE_ADDR_BITS:0]   w_tab_idx;
    logic [TABLE_ADDR_BITS:0]   n_addr;
    logic [PHASE_BITS-1:0]      n_tri_u;
    logic [TABLE_ADDR_BITS:0]   r2_addr;
    logic                       r2_sine_neg;
    logic                       r2_sq_neg;
    logic [PHASE_BITS-1:0]      r2_tri_u;

    assign w_sine_phase = r1_phase + PHASE_BITS'(r_phase_offset);
    assign w_quad       = w_sine_phase[PHASE_BITS-1 -: 2];
    assign w_tab_idx    = {1'b0, w_sine_phase[PHASE_BITS-3 -: TABLE_ADDR_BITS]};
    assign n_addr       = w_quad[0] ? (TAB_END - w_tab_idx) : w_tab_idx;
    assign n_tri_u      = r1_phase[PHASE_BITS-1] ? (~r1_phase + PHASE_BITS'(1)) : r1_phase;

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r2_addr     <= n_addr;
            r2_sine_neg <= w_quad[1];
            r2_sq_neg   <= r1_phase[PHASE_BITS-1];
            r2_tri_u    <= n_tri_u;
        end
    end

    // Stage 3: table read, triangle amplitude multiply
    logic [SAMPLE_BITS-2:0] w_mag;
    logic                   r3_sine_neg;
    logic                   r3_sq_neg;
    logic [TRI_W-1:0]       r3_tri_prod;

    wsg_sine_rom #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_sine_rom (
        .i_clk  (i_clk),
        .i_en   (w_en3),
        .i_addr (r2_addr),
        .o_data (w_mag)
    );

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r3_sine_neg <= r2_sine_neg;
            r3_sq_neg   <= r2_sq_neg;
            r3_tri_prod <= TRI_W'(r_peak_level) * TRI_W'(r2_tri_u);
        end
    end

    // Stage 4: sine amplitude multiply, triangle rounding
    logic [TRI_W-1:0]       w_tri_round;
    logic                   r4_sine_neg;
    logic                   r4_sq_neg;
    logic [SIN_W-1:0]       r4_sine_prod;
    logic [LEVEL_W-1:0]     r4_tri_val;

    assign w_tri_round = r3_tri_prod + TRI_HALF;

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r4_sine_neg  <= r3_sine_neg;
            r4_sq_neg    <= r3_sq_neg;
            r4_sine_prod <= SIN_W'(w_mag) * SIN_W'(r_peak_level);
            r4_tri_val   <= w_tri_round[PHASE_BITS+13 : PHASE_BITS-1];
        end
    end

    // Stage 5: sine rounding, sign and waveform select
    logic [SIN_W-1:0]       w_sine_round;
    logic [VAL_W-1:0]       w_sine_mag;
    logic [VAL_W-1:0]       w_level;
    logic [VAL_W-1:0]       n_value;
    logic [SAMPLE_BITS-1:0] r5_sample;

    assign w_sine_round = r4_sine_prod + SIN_HALF;
    assign w_sine_mag   = VAL_W'(w_sine_round[SAMPLE_BITS+13 : SAMPLE_BITS-1]);
    assign w_level      = VAL_W'(r_peak_level);

    always_comb begin
        unique case (r_wave_mode)
            WAVE_SINE:     n_value = r4_sine_neg ? (VAL_W'(0) - w_sine_mag) : w_sine_mag;
            WAVE_SQUARE:   n_value = r4_sq_neg ? (VAL_W'(0) - w_level) : w_level;
            WAVE_TRIANGLE: n_value = VAL_W'(r4_tri_val);
            default:       n_value = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en5) begin
            r5_sample <= n_value[SAMPLE_BITS-1:0];
        end
    end

    assign o_m_axis_tdata = TDATA_W'(r5_sample);

endmodule
